/* src/cube_map_face_texel_address_core_macros.svh */
// Assertion macros shared by the checker of the cube map texel address core.
// Depends on nothing; included by the checker file only.
`ifndef CUBE_MAP_FACE_TEXEL_ADDRESS_CORE_MACROS_SVH
`define CUBE_MAP_FACE_TEXEL_ADDRESS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CMFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CMFA_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cmfa_pkg.sv */
// Shared types, constants and helpers of the cube map texel address core.
// Depends on nothing; every other file but the macro header refers to it by scoped names.
package cmfa_pkg;

  localparam int unsigned MAX_FACE_SIZE_DEF  = 256;
  localparam int unsigned COMPONENT_BITS_DEF = 16;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned FACE_W  = 3;
  localparam int unsigned TEXEL_W = 8;
  localparam int unsigned INDEX_W = 19;

  localparam logic [CFG_W-1:0] CFG_FACE_SIZE_RESET = 9'd256;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef struct packed {
    face_t face;
    logic  zero;
  } tag_t;

  // Bits of a texel coordinate: enough for max_size - 1, at least one.
  function automatic int unsigned quot_bits(int unsigned max_size);
    if (max_size <= 1) begin
      return 1;
    end
    return $clog2(max_size);
  endfunction

endpackage

/* src/cube_map_face_texel_address_core.sv */
// Cube map face selection with nearest texel addressing. Each input beat carries a
// direction vector; the core picks the face by the major axis (ties go to x, then y),
// maps the two minor components to a column and row as
// floor((num + major) * (size - 1) / (2 * major)) exactly, and returns face, column,
// row, the linear address face*size*size + row*size + column, and a flag for the zero
// vector (face 1, texel 0). One beat is accepted every clock while the output is not
// stalled; the restoring divider produces one quotient bit per stage for both
// coordinates. Back-pressure stalls only as far as needed: empty stages keep filling
// while the output waits. A write to the face size register passes through that
// register, then the size and span registers, and the squared size one more.
// Depends on cmfa_pkg, cmfa_front, cmfa_div and cmfa_addr.
module cube_map_face_texel_address_core #(
  parameter int unsigned MAX_FACE_SIZE  = cmfa_pkg::MAX_FACE_SIZE_DEF,
  parameter int unsigned COMPONENT_BITS = cmfa_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [cmfa_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COMPONENT_BITS-1:0]    in_dir_x,
  input  logic signed [COMPONENT_BITS-1:0]    in_dir_y,
  input  logic signed [COMPONENT_BITS-1:0]    in_dir_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cmfa_pkg::FACE_W-1:0]         out_face,
  output logic [cmfa_pkg::TEXEL_W-1:0]        out_texel_x,
  output logic [cmfa_pkg::TEXEL_W-1:0]        out_texel_y,
  output logic [cmfa_pkg::INDEX_W-1:0]        out_texel_index,
  output logic                                out_zero_direction
);

  localparam int unsigned QW = cmfa_pkg::quot_bits(MAX_FACE_SIZE);
  localparam int unsigned ZW = $clog2(MAX_FACE_SIZE + 1);
  localparam int unsigned DW = COMPONENT_BITS + 1;
  localparam int unsigned TW = DW + QW;

  logic [cmfa_pkg::CFG_W-1:0] cfg_face_size_r;
  logic [ZW-1:0]              size_nxt, size_r;
  logic [QW-1:0]              span_r;
  logic [2*ZW-1:0]            size_sq_r;

  logic           f_valid, f_ready;
  cmfa_pkg::tag_t f_tag;
  logic [DW-1:0]  f_den;
  logic [TW-1:0]  f_top_u, f_top_v;

  logic           d_valid, d_ready;
  cmfa_pkg::tag_t d_tag;
  logic [QW-1:0]  d_q_u, d_q_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_face_size_r <= cmfa_pkg::CFG_FACE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      cfg_face_size_r <= cfg_wr_data;
    end
  end

  // A size of zero counts as one; sizes above the maximum saturate.
  always_comb begin
    if (cfg_face_size_r == '0) begin
      size_nxt = ZW'(1);
    end else if (32'(cfg_face_size_r) > MAX_FACE_SIZE) begin
      size_nxt = ZW'(MAX_FACE_SIZE);
    end else begin
      size_nxt = ZW'(cfg_face_size_r);
    end
  end

  always_ff @(posedge clk) begin
    size_r    <= size_nxt;
    span_r    <= QW'(size_nxt - ZW'(1));
    size_sq_r <= (2*ZW)'(size_r) * (2*ZW)'(size_r);
  end

  cmfa_front #(
    .MAX_FACE_SIZE  (MAX_FACE_SIZE),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .span     (span_r),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_tag   (f_tag),
    .dn_den   (f_den),
    .dn_top_u (f_top_u),
    .dn_top_v (f_top_v)
  );

  cmfa_div #(
    .MAX_FACE_SIZE  (MAX_FACE_SIZE),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_tag   (f_tag),
    .up_den   (f_den),
    .up_top_u (f_top_u),
    .up_top_v (f_top_v),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_tag   (d_tag),
    .dn_q_u   (d_q_u),
    .dn_q_v   (d_q_v)
  );

  cmfa_addr #(
    .MAX_FACE_SIZE (MAX_FACE_SIZE)
  ) u_addr (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (d_valid),
    .up_ready       (d_ready),
    .up_tag         (d_tag),
    .up_q_u         (d_q_u),
    .up_q_v         (d_q_v),
    .size           (size_r),
    .size_sq        (size_sq_r),
    .dn_valid       (out_valid),
    .dn_ready       (out_ready),
    .face           (out_face),
    .texel_x        (out_texel_x),
    .texel_y        (out_texel_y),
    .texel_index    (out_texel_index),
    .zero_direction (out_zero_direction)
  );

endmodule

/* src/cmfa_front.sv */
// Front pipeline: absolute values, major axis and face choice, numerators and the
// scaled dividends. Four register stages. Depends on cmfa_pkg.
module cmfa_front #(
  parameter int unsigned MAX_FACE_SIZE  = cmfa_pkg::MAX_FACE_SIZE_DEF,
  parameter int unsigned COMPONENT_BITS = cmfa_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   up_valid,
  output logic                                                   up_ready,
  input  logic signed [COMPONENT_BITS-1:0]                       dir_x,
  input  logic signed [COMPONENT_BITS-1:0]                       dir_y,
  input  logic signed [COMPONENT_BITS-1:0]                       dir_z,
  input  logic [cmfa_pkg::quot_bits(MAX_FACE_SIZE)-1:0]          span,
  output logic                                                   dn_valid,
  input  logic                                                   dn_ready,
  output cmfa_pkg::tag_t                                         dn_tag,
  output logic [COMPONENT_BITS:0]                                dn_den,
  output logic [COMPONENT_BITS+cmfa_pkg::quot_bits(MAX_FACE_SIZE):0] dn_top_u,
  output logic [COMPONENT_BITS+cmfa_pkg::quot_bits(MAX_FACE_SIZE):0] dn_top_v
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned QW = cmfa_pkg::quot_bits(MAX_FACE_SIZE);
  localparam int unsigned DW = CB + 1;
  localparam int unsigned TW = DW + QW;
  localparam int unsigned NS = 4;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  logic [NS:0]   vchain;

  // Stage 0: raw components and magnitudes.
  logic signed [CB-1:0] dx_r, dy_r, dz_r;
  logic [CB-1:0]        ax_r, ay_r, az_r;
  logic [CB-1:0]        ax_nxt, ay_nxt, az_nxt;

  // Stage 1: face, major magnitude and signed numerators.
  cmfa_pkg::tag_t       tag1_r, tag1_nxt;
  logic [CB-1:0]        major1_r, major1_nxt;
  logic signed [DW-1:0] nu1_r, nv1_r, nu1_nxt, nv1_nxt;
  logic signed [DW-1:0] ex, ey, ez;
  logic                 px, py, pz;

  // Stage 2: biased numerators and the divisor.
  cmfa_pkg::tag_t tag2_r;
  logic [DW-1:0]  su2_r, sv2_r, den2_r;
  logic [DW:0]    su_sum, sv_sum;

  // Stage 3: dividends scaled by the span.
  cmfa_pkg::tag_t tag3_r;
  logic [DW-1:0]  den3_r;
  logic [TW-1:0]  tu3_r, tv3_r;

  assign vchain = {v_r, up_valid};

  always_comb begin
    en[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= vchain[k];
        end
      end
    end
  end

  assign ax_nxt = dir_x[CB-1] ? CB'(-dir_x) : dir_x;
  assign ay_nxt = dir_y[CB-1] ? CB'(-dir_y) : dir_y;
  assign az_nxt = dir_z[CB-1] ? CB'(-dir_z) : dir_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= dir_x;
      dy_r <= dir_y;
      dz_r <= dir_z;
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      az_r <= az_nxt;
    end
  end

  // Ties go to x, then to y. A major component that is not positive picks
  // the negative face.
  always_comb begin
    ex = {dx_r[CB-1], dx_r};
    ey = {dy_r[CB-1], dy_r};
    ez = {dz_r[CB-1], dz_r};
    px = !dx_r[CB-1] && (dx_r != '0);
    py = !dy_r[CB-1] && (dy_r != '0);
    pz = !dz_r[CB-1] && (dz_r != '0);
    if (ax_r >= ay_r && ax_r >= az_r) begin
      major1_nxt    = ax_r;
      tag1_nxt.face = px ? cmfa_pkg::FACE_PX : cmfa_pkg::FACE_NX;
      nu1_nxt       = px ? -ez : ez;
      nv1_nxt       = -ey;
    end else if (ay_r >= az_r) begin
      major1_nxt    = ay_r;
      tag1_nxt.face = py ? cmfa_pkg::FACE_PY : cmfa_pkg::FACE_NY;
      nu1_nxt       = ex;
      nv1_nxt       = py ? ez : -ez;
    end else begin
      major1_nxt    = az_r;
      tag1_nxt.face = pz ? cmfa_pkg::FACE_PZ : cmfa_pkg::FACE_NZ;
      nu1_nxt       = pz ? ex : -ex;
      nv1_nxt       = -ey;
    end
    tag1_nxt.zero = (major1_nxt == '0);
    if (tag1_nxt.zero) begin
      tag1_nxt.face = cmfa_pkg::FACE_NX;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tag1_r   <= tag1_nxt;
      major1_r <= major1_nxt;
      nu1_r    <= nu1_nxt;
      nv1_r    <= nv1_nxt;
    end
  end

  // The numerator never drops below minus the major magnitude, so the sum is
  // non-negative and fits in DW bits.
  assign su_sum = {nu1_r[DW-1], nu1_r} + {2'b00, major1_r};
  assign sv_sum = {nv1_r[DW-1], nv1_r} + {2'b00, major1_r};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tag2_r <= tag1_r;
      su2_r  <= su_sum[DW-1:0];
      sv2_r  <= sv_sum[DW-1:0];
      den2_r <= {major1_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      tag3_r <= tag2_r;
      den3_r <= den2_r;
      tu3_r  <= TW'(su2_r) * TW'(span);
      tv3_r  <= TW'(sv2_r) * TW'(span);
    end
  end

  assign dn_valid = v_r[NS-1];
  assign dn_tag   = tag3_r;
  assign dn_den   = den3_r;
  assign dn_top_u = tu3_r;
  assign dn_top_v = tv3_r;

endmodule

/* src/cmfa_div.sv */
// Restoring divider pipeline for both texel coordinates, one quotient bit per
// register stage. Depends on cmfa_pkg.
module cmfa_div #(
  parameter int unsigned MAX_FACE_SIZE  = cmfa_pkg::MAX_FACE_SIZE_DEF,
  parameter int unsigned COMPONENT_BITS = cmfa_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   up_valid,
  output logic                                                   up_ready,
  input  cmfa_pkg::tag_t                                         up_tag,
  input  logic [COMPONENT_BITS:0]                                up_den,
  input  logic [COMPONENT_BITS+cmfa_pkg::quot_bits(MAX_FACE_SIZE):0] up_top_u,
  input  logic [COMPONENT_BITS+cmfa_pkg::quot_bits(MAX_FACE_SIZE):0] up_top_v,
  output logic                                                   dn_valid,
  input  logic                                                   dn_ready,
  output cmfa_pkg::tag_t                                         dn_tag,
  output logic [cmfa_pkg::quot_bits(MAX_FACE_SIZE)-1:0]          dn_q_u,
  output logic [cmfa_pkg::quot_bits(MAX_FACE_SIZE)-1:0]          dn_q_v
);

  localparam int unsigned QW = cmfa_pkg::quot_bits(MAX_FACE_SIZE);
  localparam int unsigned DW = COMPONENT_BITS + 1;
  localparam int unsigned TW = DW + QW;

  logic [QW-1:0] v_r;
  logic [QW:0]   en;
  logic [QW:0]   vchain;

  cmfa_pkg::tag_t tag_r [QW];
  logic [DW-1:0]  den_r [QW];
  logic [TW-1:0]  ru_r  [QW];
  logic [TW-1:0]  rv_r  [QW];
  logic [QW-1:0]  qu_r  [QW];
  logic [QW-1:0]  qv_r  [QW];

  assign vchain = {v_r, up_valid};

  always_comb begin
    en[QW] = dn_ready;
    for (int k = QW - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < QW; k++) begin
        if (en[k]) begin
          v_r[k] <= vchain[k];
        end
      end
    end
  end

  // Stage k settles quotient bit QW-1-k. The dividend is below the divisor
  // times 2**QW, so the first stage never overflows its bit.
  for (genvar k = 0; k < QW; k++) begin : g_step
    cmfa_pkg::tag_t tag_in;
    logic [DW-1:0]  den_in;
    logic [TW-1:0]  ru_in, rv_in, dsh;
    logic [QW-1:0]  qu_in, qv_in;

    if (k == 0) begin : g_first
      assign tag_in = up_tag;
      assign den_in = up_den;
      assign ru_in  = up_top_u;
      assign rv_in  = up_top_v;
      assign qu_in  = '0;
      assign qv_in  = '0;
    end else begin : g_rest
      assign tag_in = tag_r[k-1];
      assign den_in = den_r[k-1];
      assign ru_in  = ru_r[k-1];
      assign rv_in  = rv_r[k-1];
      assign qu_in  = qu_r[k-1];
      assign qv_in  = qv_r[k-1];
    end

    assign dsh = TW'(den_in) << (QW - 1 - k);

    always_ff @(posedge clk) begin
      if (en[k]) begin
        tag_r[k] <= tag_in;
        den_r[k] <= den_in;
        if (ru_in >= dsh) begin
          ru_r[k] <= ru_in - dsh;
          qu_r[k] <= qu_in | (QW'(1) << (QW - 1 - k));
        end else begin
          ru_r[k] <= ru_in;
          qu_r[k] <= qu_in;
        end
        if (rv_in >= dsh) begin
          rv_r[k] <= rv_in - dsh;
          qv_r[k] <= qv_in | (QW'(1) << (QW - 1 - k));
        end else begin
          rv_r[k] <= rv_in;
          qv_r[k] <= qv_in;
        end
      end
    end
  end

  assign dn_valid = v_r[QW-1];
  assign dn_tag   = tag_r[QW-1];
  assign dn_q_u   = qu_r[QW-1];
  assign dn_q_v   = qv_r[QW-1];

endmodule

/* src/cmfa_addr.sv */
// Address pipeline: forces the zero-direction texel, forms the linear texel
// address in two stages and holds the output register. Depends on cmfa_pkg.
module cmfa_addr #(
  parameter int unsigned MAX_FACE_SIZE = cmfa_pkg::MAX_FACE_SIZE_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  cmfa_pkg::tag_t                                up_tag,
  input  logic [cmfa_pkg::quot_bits(MAX_FACE_SIZE)-1:0] up_q_u,
  input  logic [cmfa_pkg::quot_bits(MAX_FACE_SIZE)-1:0] up_q_v,
  input  logic [$clog2(MAX_FACE_SIZE+1)-1:0]            size,
  input  logic [2*$clog2(MAX_FACE_SIZE+1)-1:0]          size_sq,
  output logic                                          dn_valid,
  input  logic                                          dn_ready,
  output logic [cmfa_pkg::FACE_W-1:0]                   face,
  output logic [cmfa_pkg::TEXEL_W-1:0]                  texel_x,
  output logic [cmfa_pkg::TEXEL_W-1:0]                  texel_y,
  output logic [cmfa_pkg::INDEX_W-1:0]                  texel_index,
  output logic                                          zero_direction
);

  localparam int unsigned QW = cmfa_pkg::quot_bits(MAX_FACE_SIZE);
  localparam int unsigned ZW = $clog2(MAX_FACE_SIZE + 1);
  localparam int unsigned IW = 2 * ZW + 3;
  localparam int unsigned NS = 2;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  logic [NS:0]   vchain;

  logic [QW-1:0]  tx_nxt, ty_nxt;
  cmfa_pkg::tag_t tag0_r, tag1_r;
  logic [QW-1:0]  tx0_r, ty0_r, tx1_r, ty1_r;
  logic [IW-1:0]  pf0_r, pr0_r, idx1_r;

  assign vchain = {v_r, up_valid};

  always_comb begin
    en[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= vchain[k];
        end
      end
    end
  end

  // A zero direction divides by zero upstream; its texel is pinned to (0,0).
  assign tx_nxt = up_tag.zero ? '0 : up_q_u;
  assign ty_nxt = up_tag.zero ? '0 : up_q_v;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tag0_r <= up_tag;
      tx0_r  <= tx_nxt;
      ty0_r  <= ty_nxt;
      pf0_r  <= IW'(up_tag.face) * IW'(size_sq);
      pr0_r  <= IW'(ty_nxt) * IW'(size);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tag1_r <= tag0_r;
      tx1_r  <= tx0_r;
      ty1_r  <= ty0_r;
      idx1_r <= pf0_r + pr0_r + IW'(tx0_r);
    end
  end

  assign dn_valid       = v_r[NS-1];
  assign face           = tag1_r.face;
  assign zero_direction = tag1_r.zero;
  assign texel_x        = cmfa_pkg::TEXEL_W'(tx1_r);
  assign texel_y        = cmfa_pkg::TEXEL_W'(ty1_r);
  assign texel_index    = cmfa_pkg::INDEX_W'(idx1_r);

endmodule

/* src/cmfa_checker.sv */
// Port-level checker for the cube map texel address core, bound to the top level.
// Depends on cmfa_pkg and cube_map_face_texel_address_core_macros.svh.
`include "cube_map_face_texel_address_core_macros.svh"

module cmfa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cmfa_pkg::FACE_W-1:0] out_face,
  input logic [cmfa_pkg::TEXEL_W-1:0] out_texel_x,
  input logic [cmfa_pkg::TEXEL_W-1:0] out_texel_y,
  input logic [cmfa_pkg::INDEX_W-1:0] out_texel_index,
  input logic                        out_zero_direction
);

  // A zero direction always lands on texel (0,0) of the negative x face.
  `CMFA_ASSERT_IMP(a_zero_texel, clk, rst_n, out_valid && out_zero_direction, out_face == cmfa_pkg::FACE_NX && out_texel_x == '0 && out_texel_y == '0, "zero direction beat not at face 1 texel 0")

  // A result beat that is not taken stays put.
  `CMFA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_face) && $stable(out_texel_index) && $stable(out_zero_direction), "stalled result beat changed")

  // Reset empties the pipeline.
  `CMFA_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result beat valid right after reset")

endmodule

bind cube_map_face_texel_address_core cmfa_checker u_cmfa_checker (.*);

/* dv/cube_map_face_texel_address_core_tb.sv */
// Testbench for cube_map_face_texel_address_core: directed and random direction beats
// are checked against an in-bench predictor, over several face sizes and with stalls.
// Depends on cmfa_pkg and the core RTL.
module cube_map_face_texel_address_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB       = cmfa_pkg::COMPONENT_BITS_DEF;
  localparam int unsigned MAX_SIZE = cmfa_pkg::MAX_FACE_SIZE_DEF;
  localparam int unsigned LATENCY  = 6 + $clog2(MAX_SIZE);
  localparam int unsigned SETTLE   = LATENCY + 4;
  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned HOLD_OFF = 200;

  typedef logic signed [CB-1:0] comp_t;

  typedef struct packed {
    cmfa_pkg::face_t              face;
    logic [cmfa_pkg::TEXEL_W-1:0] col;
    logic [cmfa_pkg::TEXEL_W-1:0] row;
    logic [cmfa_pkg::INDEX_W-1:0] addr;
    logic                         zero;
  } texel_beat_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [cmfa_pkg::CFG_W-1:0]   cfg_wr_data;
  logic                         in_valid;
  logic                         in_ready;
  comp_t                        in_dir_x;
  comp_t                        in_dir_y;
  comp_t                        in_dir_z;
  logic                         out_valid;
  logic                         out_ready;
  logic [cmfa_pkg::FACE_W-1:0]  out_face;
  logic [cmfa_pkg::TEXEL_W-1:0] out_texel_x;
  logic [cmfa_pkg::TEXEL_W-1:0] out_texel_y;
  logic [cmfa_pkg::INDEX_W-1:0] out_texel_index;
  logic                         out_zero_direction;

  texel_beat_t                pending_texels[$];
  logic [cmfa_pkg::CFG_W-1:0] face_size_cfg = cmfa_pkg::CFG_FACE_SIZE_RESET;
  int unsigned                mismatches = 0;
  int unsigned                stuck_cycles = 0;
  bit                         tx_idle_en = 1;
  bit                         rx_idle_en = 1;
  int unsigned                hold_req = 0;

  cube_map_face_texel_address_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_dir_x           (in_dir_x),
    .in_dir_y           (in_dir_y),
    .in_dir_z           (in_dir_z),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_face           (out_face),
    .out_texel_x        (out_texel_x),
    .out_texel_y        (out_texel_y),
    .out_texel_index    (out_texel_index),
    .out_zero_direction (out_zero_direction)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Floor of (num + major) * span / (2 * major); num + major is never negative.
  function automatic logic [cmfa_pkg::TEXEL_W-1:0] scale_to_texel(int num, int major,
                                                                  int span);
    longint top;
    longint t;
    top = longint'(num + major) * span;
    t = top / (2 * longint'(major));
    if (t > span) begin
      t = span;
    end
    return t[cmfa_pkg::TEXEL_W-1:0];
  endfunction

  function automatic texel_beat_t predict_texel(comp_t dx, comp_t dy, comp_t dz,
                                                logic [cmfa_pkg::CFG_W-1:0] size_reg);
    int sx, sy, sz, ax, ay, az;
    int size, major, nu, nv, addr;
    texel_beat_t r;
    sx = dx;
    sy = dy;
    sz = dz;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    size = size_reg;
    if (size < 1) begin
      size = 1;
    end
    if (size > MAX_SIZE) begin
      size = MAX_SIZE;
    end
    if (ax >= ay && ax >= az) begin
      major = ax;
      r.face = (sx > 0) ? cmfa_pkg::FACE_PX : cmfa_pkg::FACE_NX;
      nu = (sx > 0) ? -sz : sz;
      nv = -sy;
    end else if (ay >= az) begin
      major = ay;
      r.face = (sy > 0) ? cmfa_pkg::FACE_PY : cmfa_pkg::FACE_NY;
      nu = sx;
      nv = (sy > 0) ? sz : -sz;
    end else begin
      major = az;
      r.face = (sz > 0) ? cmfa_pkg::FACE_PZ : cmfa_pkg::FACE_NZ;
      nu = (sz > 0) ? sx : -sx;
      nv = -sy;
    end
    r.zero = (major == 0);
    if (r.zero) begin
      r.face = cmfa_pkg::FACE_NX;
      r.col = '0;
      r.row = '0;
    end else begin
      r.col = scale_to_texel(nu, major, size - 1);
      r.row = scale_to_texel(nv, major, size - 1);
    end
    addr = int'(r.face) * size * size + int'(r.row) * size + int'(r.col);
    r.addr = addr[cmfa_pkg::INDEX_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Called and returns at a falling edge; valid stays high on return so that the next
  // beat can follow back to back. Callers lower it before anything else.
  task automatic send_direction(comp_t x, comp_t y, comp_t z);
    int gap;
    int r;
    gap = 0;
    if (tx_idle_en) begin
      r = $urandom_range(0, 99);
      if (r >= 95) begin
        gap = $urandom_range(10, 40);
      end else if (r >= 65) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_dir_x = x;
    in_dir_y = y;
    in_dir_z = z;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    pending_texels = {pending_texels, predict_texel(x, y, z, face_size_cfg)};
    @(negedge clk);
  endtask

  function automatic comp_t rand_component();
    case ($urandom_range(0, 5))
      0, 1, 2: return comp_t'($urandom);
      3:       return comp_t'(int'($urandom_range(0, 16)) - 8);
      4: begin
        case ($urandom_range(0, 4))
          0:       return comp_t'(16'sh8000);
          1:       return comp_t'(16'sh7FFF);
          2:       return comp_t'(0);
          3:       return comp_t'(-1);
          default: return comp_t'(1);
        endcase
      end
      default: return comp_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic send_random_direction();
    comp_t x, y, z;
    int r;
    x = rand_component();
    y = rand_component();
    z = rand_component();
    r = $urandom_range(0, 99);
    // Equal magnitudes exercise the tie rules between axes.
    if (r < 8) begin
      y = $urandom_range(0, 1) ? x : -x;
    end else if (r < 16) begin
      z = $urandom_range(0, 1) ? y : -y;
    end else if (r < 22) begin
      z = $urandom_range(0, 1) ? x : -x;
    end else if (r < 26) begin
      y = $urandom_range(0, 1) ? x : -x;
      z = $urandom_range(0, 1) ? x : -x;
    end else if (r < 28) begin
      x = '0;
      y = '0;
      z = '0;
    end
    send_direction(x, y, z);
  endtask

  // The register is only written with the core drained and the input quiet.
  task automatic write_face_size(logic [cmfa_pkg::CFG_W-1:0] value);
    in_valid = 1'b0;
    while (pending_texels.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
    cfg_wr_data = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    face_size_cfg = value;
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic test_directed();
    send_direction(0, 0, 0);
    send_direction(16384, 0, 0);
    send_direction(-16384, 0, 0);
    send_direction(0, 16384, 0);
    send_direction(0, -16384, 0);
    send_direction(0, 0, 16384);
    send_direction(0, 0, -16384);
    send_direction(16384, 16384, 16384);
    send_direction(-16384, 16384, 16384);
    send_direction(0, 16384, -16384);
    send_direction(0, -16384, 16384);
    send_direction(16384, 16384, -16384);
    send_direction(-32768, 32767, -32768);
    send_direction(32767, -32768, 32767);
    send_direction(-32768, -32768, -32768);
    send_direction(32767, 32767, 32767);
    send_direction(1, 0, 0);
    send_direction(0, 0, -1);
    send_direction(-1, 1, 0);
    send_direction(3, -2, 2);
  endtask

  task automatic test_random_beats(int count);
    repeat (count) send_random_direction();
  endtask

  task automatic test_face_sizes();
    logic [cmfa_pkg::CFG_W-1:0] sizes[10];
    sizes = '{9'd1, 9'd0, 9'd511, 9'd2, 9'd3, 9'd255, 9'd300, 9'd17, 9'd0, 9'd256};
    sizes[8] = $urandom_range(4, 254);
    foreach (sizes[i]) begin
      write_face_size(sizes[i]);
      send_direction(16384, -16384, 16384);
      send_direction(0, 0, 0);
      test_random_beats(34);
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the pipe fills up.
  task automatic test_backpressure();
    tx_idle_en = 0;
    hold_req = HOLD_OFF;
    test_random_beats(60);
    tx_idle_en = 1;
  endtask

  task automatic test_no_idle();
    tx_idle_en = 0;
    rx_idle_en = 0;
    test_random_beats(60);
    tx_idle_en = 1;
    rx_idle_en = 1;
  endtask

  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int r;
    stall_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (rx_idle_en) begin
        r = $urandom_range(0, 99);
        if (r >= 95) begin
          stall_left = $urandom_range(10, 40) - 1;
          out_ready = 1'b0;
        end else if (r >= 65) begin
          stall_left = $urandom_range(1, 3) - 1;
          out_ready = 1'b0;
        end else begin
          out_ready = 1'b1;
        end
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_beat
    texel_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_texels.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_texels.pop_front();
        if (out_face !== want.face) begin
          report_mismatch($sformatf("face got %0d want %0d", out_face, want.face));
        end
        if (out_texel_x !== want.col) begin
          report_mismatch($sformatf("texel_x got %0d want %0d", out_texel_x, want.col));
        end
        if (out_texel_y !== want.row) begin
          report_mismatch($sformatf("texel_y got %0d want %0d", out_texel_y, want.row));
        end
        if (out_texel_index !== want.addr) begin
          report_mismatch($sformatf("texel_index got %0d want %0d",
                                    out_texel_index, want.addr));
        end
        if (out_zero_direction !== want.zero) begin
          report_mismatch($sformatf("zero_direction got %0b want %0b",
                                    out_zero_direction, want.zero));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
      $display("cube_map_face_texel_address_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_dir_x = '0;
    in_dir_y = '0;
    in_dir_z = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_beats(160);
    test_backpressure();
    test_no_idle();
    test_face_sizes();
    test_random_beats(40);

    in_valid = 1'b0;
    while (pending_texels.size() != 0) begin
      @(negedge clk);
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_texels.size() != 0) begin
      report_mismatch("expected results left over");
    end
    if (mismatches == 0) begin
      $display("cube_map_face_texel_address_core_tb OK");
    end else begin
      $display("cube_map_face_texel_address_core_tb NOT OK");
    end
    $finish;
  end

endmodule
